/* sv/kau_pkg.sv */
// Package for the k-means assign/update core: command and result codes,
// payload structs shared by the front end, queue and back end. No dependencies.
`default_nettype none
package kau_pkg;
   localparam int CLUSTER_W = 3;
   localparam int DIM_W     = 4;
   localparam int VALUE_W   = 16;
   localparam int DIST_W    = 20;
   localparam int SUM_W     = 32;
   localparam int PNORM_W   = 3;
   localparam logic [DIST_W-1:0] ACC_MAX = '1;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_POINT  = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ASSIGN = 2'd0,
      KIND_READ   = 2'd1,
      KIND_UPDATE = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [CLUSTER_W-1:0] cluster;
      logic [DIM_W-1:0]     dim;
      logic [VALUE_W-1:0]   value;
      logic                 last;
   } req_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [CLUSTER_W-1:0] nearest;
      logic [DIST_W-1:0]    min_distance;
      logic [VALUE_W-1:0]   read_value;
   } rsp_type;

   // front-end classified word
   typedef struct packed {
      cmd_type              cmd;
      logic                 in_range;
      logic [CLUSTER_W-1:0] cluster;
      logic [DIM_W-1:0]     dim;
      logic [VALUE_W-1:0]   value;
      logic                 last;
   } op_type;
endpackage
`default_nettype wire

/* sv/kau_if.sv */
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing but its type parameter.
`default_nettype none
interface kau_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/kau_front.sv */
// Front end: accepts request words, range-checks indexes, pushes ops into
// a small FIFO toward the back end. Depends on kau_pkg.
`default_nettype none
module kau_front #(
   parameter int CLUSTERS = 8,
   parameter int DIMS     = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire kau_pkg::req_type in_data,
   output logic                  op_valid,
   input  wire logic             op_ready,
   output kau_pkg::op_type       op_data
);
   localparam int DEPTH = 4;
   kau_pkg::op_type fifo_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   kau_pkg::op_type op_new;
   logic push, pop;
   logic cl_ok, dm_ok;

   always_comb begin
      cl_ok = ({29'd0, in_data.cluster} < CLUSTERS);
      dm_ok = ({28'd0, in_data.dim} < DIMS);
      op_new.cmd      = kau_pkg::cmd_type'(in_data.command);
      op_new.in_range = dm_ok && (cl_ok || in_data.command == kau_pkg::CMD_POINT);
      op_new.cluster  = in_data.cluster;
      op_new.dim      = in_data.dim;
      op_new.value    = in_data.value;
      op_new.last     = in_data.last;
   end

   assign in_ready = (cnt_ff != 3'(DEPTH));
   assign op_valid = (cnt_ff != 3'd0);
   assign op_data  = fifo_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) fifo_ff[wr_ptr_ff] <= op_new;
   end
endmodule
`default_nettype wire

/* sv/kau_div.sv */
// Restoring divider, one quotient bit per cycle, for the centroid mean.
// Depends on kau_pkg for the sum width.
`default_nettype none
module kau_div #(
   parameter int DEN_W = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [kau_pkg::SUM_W-1:0] num,
   input  wire logic [DEN_W-1:0]          den,
   output logic                           done,
   output logic [kau_pkg::SUM_W-1:0]      quot
);
   localparam int SW = kau_pkg::SUM_W;
   logic [SW-1:0] q_ff, q_in;
   logic [DEN_W:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff;
   logic [5:0] n_ff, n_in;
   logic busy_ff, busy_in;
   logic [DEN_W:0] trial;

   always_comb begin
      trial   = {r_ff[DEN_W-1:0], q_ff[SW-1]};
      q_in    = {q_ff[SW-2:0], 1'b0};
      r_in    = trial;
      if (trial >= {1'b0, d_ff}) begin
         r_in    = trial - {1'b0, d_ff};
         q_in[0] = 1'b1;
      end
      n_in    = n_ff - 6'd1;
      busy_in = busy_ff && (n_ff != 6'd1);
   end

   assign done = busy_ff && (n_ff == 6'd1);
   assign quot = q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff    <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         n_ff    <= 6'(SW);
      end else if (busy_ff) begin
         busy_ff <= busy_in;
         n_ff    <= n_in;
      end
      if (start) begin
         q_ff <= num;
         r_ff <= '0;
         d_ff <= den;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end
endmodule
`default_nettype wire

/* sv/kau_back.sv */
// Back end: centroid/sum memories, distance accumulation per cluster over
// cycles, point close, update pass with divider, and output register.
// Depends on kau_pkg and kau_div.
`default_nettype none
module kau_back #(
   parameter int CLUSTERS   = 8,
   parameter int DIMS       = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [kau_pkg::PNORM_W-1:0] p_norm,
   input  wire logic                        op_valid,
   output logic                             op_ready,
   input  wire kau_pkg::op_type             op_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output kau_pkg::rsp_type                 rsp_data
);
   localparam int KW   = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int DW   = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int AW   = KW + DW;
   localparam int ENT  = CLUSTERS * DIMS;
   localparam int VW   = kau_pkg::VALUE_W;
   localparam int SW   = kau_pkg::SUM_W;
   localparam int DSW  = kau_pkg::DIST_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b00000000001,
      ST_IDLE   = 11'b00000000010,
      ST_RD     = 11'b00000000100,
      ST_DIFF   = 11'b00000001000,
      ST_MUL    = 11'b00000010000,
      ST_ACC    = 11'b00000100000,
      ST_MIN    = 11'b00001000000,
      ST_SUMRD  = 11'b00010000000,
      ST_SUMWR  = 11'b00100000000,
      ST_UPRD   = 11'b01000000000,
      ST_UPDIV  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // memories
   logic [VW-1:0] cent_mem [ENT];
   logic [SW-1:0] sum_mem [ENT];
   logic [VW-1:0] pbuf_mem [DIMS];
   logic [VW-1:0] cent_rd_ff;
   logic [SW-1:0] sum_rd_ff;
   logic [VW-1:0] pbuf_rd_ff;
   logic [AW-1:0] c_raddr, s_raddr, c_waddr, s_waddr;
   logic c_we, s_we;
   logic [VW-1:0] c_wdata;
   logic [SW-1:0] s_wdata;

   logic [COUNT_BITS-1:0] count_ff [CLUSTERS];
   logic [DSW-1:0] acc_ff [CLUSTERS];

   kau_pkg::op_type op_ff;
   logic [KW-1:0] k_ff, k_in, best_ff;
   logic [DW-1:0] d_ff;
   logic [AW-1:0] clr_ff;
   logic [DSW-1:0] bd_ff;
   logic [1:0] pm1_ff;  // effective p minus one
   logic [VW-1:0] diff_ff;
   logic [4*VW-1:0] pw_ff;
   logic [1:0] mstep_ff;
   logic [VW-1:0] term;
   logic [4*VW-1:0] prod;

   kau_pkg::rsp_type out_ff;
   logic out_v_ff;

   logic div_start, div_done;
   logic [SW-1:0] div_q;

   kau_div #(.DEN_W(COUNT_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(sum_rd_ff), .den(count_ff[k_ff]), .done(div_done), .quot(div_q)
   );

   logic [AW-1:0] kd_addr;
   assign kd_addr = AW'({{(32-KW){1'b0}}, k_ff} * DIMS) + AW'(d_ff);

   // op_data.cluster/dim are only meaningful in range; the front end flags that
   logic [AW-1:0] ld_addr;
   assign ld_addr = AW'({{(32-kau_pkg::CLUSTER_W){1'b0}}, op_data.cluster} * DIMS
                        + {{(32-kau_pkg::DIM_W){1'b0}}, op_data.dim});

   logic [AW-1:0] pt_addr;
   assign pt_addr = AW'({{(32-KW){1'b0}}, k_ff} * DIMS
                        + {{(32-kau_pkg::DIM_W){1'b0}}, op_ff.dim});

   logic accept;
   assign op_ready = (state_ff == ST_IDLE) && !out_v_ff;
   assign accept   = op_valid && op_ready;

   // exact p^th power; the term is its top 16 bits after the 16*(p-1) shift
   assign prod = {{VW{1'b0}}, pw_ff[3*VW-1:0]} * {{3*VW{1'b0}}, diff_ff};
   assign term = (pm1_ff == 2'd0) ? diff_ff :
                 (pm1_ff == 2'd1) ? pw_ff[2*VW-1:VW] :
                 (pm1_ff == 2'd2) ? pw_ff[3*VW-1:2*VW] : pw_ff[4*VW-1:3*VW];

   logic [DSW:0] acc_sum;
   assign acc_sum = {1'b0, acc_ff[k_ff]} + {{(DSW+1-VW){1'b0}}, term};

   logic [SW:0] s_add;
   assign s_add = {1'b0, sum_rd_ff} + {{(SW+1-VW){1'b0}}, pbuf_rd_ff};

   logic last_k, last_d;
   assign last_k = (k_ff == KW'(CLUSTERS - 1));
   assign last_d = (d_ff == DW'(DIMS - 1));

   always_comb begin
      c_raddr = kd_addr; s_raddr = kd_addr;
      c_we = 1'b0; c_waddr = kd_addr; c_wdata = '0;
      s_we = 1'b0; s_waddr = kd_addr; s_wdata = '0;
      div_start = 1'b0;
      state_in = state_ff;
      k_in = k_ff;
      case (state_ff)
         ST_CLEAR: begin
            c_we = 1'b1; c_waddr = clr_ff;
            s_we = 1'b1; s_waddr = clr_ff;
            if (clr_ff == AW'(ENT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            // a point starts at centroid 0, whose row address is the dim
            c_raddr = (op_data.cmd == kau_pkg::CMD_POINT) ? AW'(op_data.dim[DW-1:0])
                                                           : ld_addr;
            if (accept) begin
               case (op_data.cmd)
                  kau_pkg::CMD_LOAD: begin
                     c_we = op_data.in_range; c_waddr = ld_addr; c_wdata = op_data.value;
                  end
                  kau_pkg::CMD_READ: state_in = ST_RD;
                  kau_pkg::CMD_UPDATE: state_in = ST_UPRD;
                  kau_pkg::CMD_POINT: state_in = op_data.in_range ? ST_DIFF :
                                                 op_data.last ? ST_MIN : ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD: state_in = ST_IDLE;
         ST_DIFF: begin
            c_raddr = pt_addr;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            c_raddr = pt_addr;
            if (mstep_ff == pm1_ff) state_in = ST_ACC;
         end
         ST_ACC: begin
            if (last_k) begin
               state_in = op_ff.last ? ST_MIN : ST_IDLE;
               k_in = '0;
            end else begin
               k_in = k_ff + KW'(1);
               state_in = ST_DIFF;
            end
            c_raddr = AW'({{(32-KW){1'b0}}, k_in} * DIMS
                          + {{(32-kau_pkg::DIM_W){1'b0}}, op_ff.dim});
         end
         ST_MIN: begin
            if (last_k) begin
               state_in = ST_SUMRD;
               k_in = '0;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         ST_SUMRD: begin
            s_raddr = AW'({{(32-KW){1'b0}}, best_ff} * DIMS) + AW'(d_ff);
            state_in = ST_SUMWR;
         end
         ST_SUMWR: begin
            s_we = (count_ff[best_ff] != CNT_MAX);
            s_waddr = AW'({{(32-KW){1'b0}}, best_ff} * DIMS) + AW'(d_ff);
            s_wdata = s_add[SW] ? '1 : s_add[SW-1:0];
            state_in = last_d ? ST_IDLE : ST_SUMRD;
         end
         ST_UPRD: begin
            state_in = ST_UPDIV;
         end
         ST_UPDIV: begin
            if (count_ff[k_ff] == '0) begin
               c_we = 1'b1; c_wdata = '0;
               s_we = 1'b1; s_wdata = '0;
               state_in = ST_UPRD;
            end else begin
               div_start = (mstep_ff == 2'd0);
               if (div_done) begin
                  c_we = 1'b1;
                  c_wdata = (div_q > SW'(16'hFFFF)) ? '1 : div_q[VW-1:0];
                  s_we = 1'b1; s_wdata = '0;
                  state_in = ST_UPRD;
               end
            end
            if (state_in == ST_UPRD) begin
               if (last_d) k_in = last_k ? '0 : k_ff + KW'(1);
               if (last_d && last_k) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (c_we) cent_mem[c_waddr] <= c_wdata;
      if (s_we) sum_mem[s_waddr] <= s_wdata;
      cent_rd_ff <= cent_mem[c_raddr];
      sum_rd_ff  <= sum_mem[s_raddr];
      pbuf_rd_ff <= pbuf_mem[d_ff];
      if (accept && op_data.cmd == kau_pkg::CMD_POINT && op_data.in_range)
         pbuf_mem[op_data.dim[DW-1:0]] <= op_data.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         k_ff     <= '0;
         d_ff     <= '0;
         mstep_ff <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < CLUSTERS; i++) begin
            count_ff[i] <= '0;
            acc_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         if (rsp_valid && rsp_ready) out_v_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + AW'(1);
            ST_IDLE: begin
               d_ff <= '0;
               if (accept) begin
                  op_ff <= op_data;
                  pm1_ff <= (p_norm == 3'd0) ? 2'd0 :
                            (p_norm >= 3'd4) ? 2'd3 : 2'(p_norm - 3'd1);
               end
            end
            ST_RD: begin
               out_v_ff <= 1'b1;
               out_ff.kind <= kau_pkg::KIND_READ;
               out_ff.nearest <= '0;
               out_ff.min_distance <= '0;
               out_ff.read_value <= op_ff.in_range ? cent_rd_ff : '0;
            end
            ST_DIFF: begin
               diff_ff  <= (op_ff.value >= cent_rd_ff) ? op_ff.value - cent_rd_ff
                                                       : cent_rd_ff - op_ff.value;
               mstep_ff <= '0;
            end
            ST_MUL: begin
               if (mstep_ff == 2'd0) pw_ff <= {{3*VW{1'b0}}, diff_ff};
               else pw_ff <= prod;
               mstep_ff <= mstep_ff + 2'd1;
            end
            ST_ACC: acc_ff[k_ff] <= acc_sum[DSW] ? kau_pkg::ACC_MAX : acc_sum[DSW-1:0];
            ST_MIN: begin
               if (k_ff == '0 || acc_ff[k_ff] < bd_ff) begin
                  bd_ff <= acc_ff[k_ff];
                  best_ff <= k_ff;
               end
               d_ff <= '0;
            end
            ST_SUMRD: ;
            ST_SUMWR: begin
               d_ff <= d_ff + DW'(1);
               if (last_d) begin
                  d_ff <= '0;
                  if (count_ff[best_ff] != CNT_MAX)
                     count_ff[best_ff] <= count_ff[best_ff] + COUNT_BITS'(1);
                  for (int i = 0; i < CLUSTERS; i++) acc_ff[i] <= '0;
                  out_v_ff <= 1'b1;
                  out_ff.kind <= kau_pkg::KIND_ASSIGN;
                  out_ff.nearest <= kau_pkg::CLUSTER_W'(best_ff);
                  out_ff.min_distance <= bd_ff;
                  out_ff.read_value <= '0;
               end
            end
            ST_UPRD: mstep_ff <= '0;
            ST_UPDIV: begin
               mstep_ff <= 2'd1;
               if (state_in != ST_UPDIV) begin
                  d_ff <= last_d ? '0 : d_ff + DW'(1);
                  if (last_d) count_ff[k_ff] <= '0;
                  if (last_d && last_k) begin
                     for (int i = 0; i < CLUSTERS; i++) acc_ff[i] <= '0;
                     out_v_ff <= 1'b1;
                     out_ff.kind <= kau_pkg::KIND_UPDATE;
                     out_ff.nearest <= '0;
                     out_ff.min_distance <= '0;
                     out_ff.read_value <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

/* sv/kmeans_assign_and_update_core.sv */
// Top level of the k-means assign/update core; ties the front end, op FIFO
// and back end together. Depends on kau_pkg, kau_if, kau_front, kau_back.
`default_nettype none
// A load word is written into the centroid memory when it is accepted; a
// read passes through ST_RD to the output register. A point coordinate is
// accepted, then takes a difference step, p multiply steps and an add per
// centroid; the last coordinate adds a nearest search and a read and write
// of the nearest cluster's sum for each dim. An update command runs the
// shared bit-serial divider for each element of a nonempty cluster and
// zeroes those of an empty one, over CLUSTERS*DIMS elements. The back end
// takes no new word while a result waits to be taken. A clearing pass over
// all CLUSTERS*DIMS entries after reset zeroes the centroid and sum memories
// before the first word is taken; a four-entry FIFO links front and back end.
module kmeans_assign_and_update_core #(
   parameter int CLUSTERS   = 8,
   parameter int DIMS       = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write,
   input  wire logic [kau_pkg::PNORM_W-1:0] csr_data,
   kau_if.sink                              req,
   kau_if.source                            rsp
);
   logic [kau_pkg::PNORM_W-1:0] p_norm_ff;
   logic op_valid, op_ready;
   kau_pkg::op_type op_data;

   always_ff @(posedge clock) begin
      if (reset) p_norm_ff <= 3'd2;
      else if (csr_write) p_norm_ff <= csr_data;
   end

   kau_front #(.CLUSTERS(CLUSTERS), .DIMS(DIMS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .op_valid(op_valid), .op_ready(op_ready), .op_data(op_data)
   );

   kau_back #(.CLUSTERS(CLUSTERS), .DIMS(DIMS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock(clock), .reset(reset), .p_norm(p_norm_ff),
      .op_valid(op_valid), .op_ready(op_ready), .op_data(op_data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
   );
endmodule
`default_nettype wire

/* bench/kmeans_assign_and_update_core_tb.sv */
// Self-checking bench for kmeans_assign_and_update_core: random and directed words,
// with a cluster tracker class that predicts every response.
// Depends on kau_pkg, kau_if and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module kmeans_assign_and_update_core_tb;
   localparam int NCL   = 8;
   localparam int NDIM  = 16;
   localparam int CMAX  = 65535;
   localparam int SETTLE = 300;

   class cluster_tracker;
      logic [15:0]     cent[NCL*NDIM];
      logic [31:0]     sums[NCL*NDIM];
      int unsigned     counts[NCL];
      logic [15:0]     pbuf[NDIM];
      logic [19:0]     acc[NCL];
      logic [2:0]      pnorm;
      kau_pkg::rsp_type expected_rsp[$];

      function new();
         foreach (cent[i]) begin
            cent[i] = '0;
            sums[i] = '0;
         end
         foreach (counts[k]) begin
            counts[k] = 0;
            acc[k] = '0;
         end
         foreach (pbuf[d]) pbuf[d] = '0;
         pnorm = 3'd2;
      endfunction

      function longint unsigned term(logic [15:0] x, logic [15:0] c, int p);
         longint unsigned d, t;
         d = (x >= c) ? longint'(x - c) : longint'(c - x);
         t = d;
         for (int i = 1; i < p; i++) t = t * d;
         return t >> (16 * (p - 1));
      endfunction

      function void absorb_word(kau_pkg::req_type w);
         kau_pkg::rsp_type r;
         int p, best;
         longint unsigned a, m;
         r = '0;
         p = (pnorm == 0) ? 1 : (pnorm > 4) ? 4 : int'(pnorm);
         case (kau_pkg::cmd_type'(w.command))
            kau_pkg::CMD_LOAD: cent[w.cluster*NDIM + w.dim] = w.value;
            kau_pkg::CMD_READ: begin
               r.kind = kau_pkg::KIND_READ;
               r.read_value = cent[w.cluster*NDIM + w.dim];
               expected_rsp.push_back(r);
            end
            kau_pkg::CMD_UPDATE: begin
               for (int k = 0; k < NCL; k++) begin
                  for (int d = 0; d < NDIM; d++) begin
                     m = 0;
                     if (counts[k] != 0) begin
                        m = longint'(sums[k*NDIM + d]) / counts[k];
                        if (m > CMAX) m = CMAX;
                     end
                     cent[k*NDIM + d] = m[15:0];
                     sums[k*NDIM + d] = '0;
                  end
                  counts[k] = 0;
                  acc[k] = '0;
               end
               r.kind = kau_pkg::KIND_UPDATE;
               expected_rsp.push_back(r);
            end
            default: begin
               pbuf[w.dim] = w.value;
               for (int k = 0; k < NCL; k++) begin
                  a = longint'(acc[k]) + term(w.value, cent[k*NDIM + w.dim], p);
                  if (a > kau_pkg::ACC_MAX) a = kau_pkg::ACC_MAX;
                  acc[k] = a[19:0];
               end
               if (w.last) begin
                  best = 0;
                  for (int k = 1; k < NCL; k++)
                     if (acc[k] < acc[best]) best = k;
                  if (counts[best] < CMAX) begin
                     counts[best]++;
                     for (int d = 0; d < NDIM; d++) begin
                        a = longint'(sums[best*NDIM + d]) + pbuf[d];
                        if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
                        sums[best*NDIM + d] = a[31:0];
                     end
                  end
                  r.kind = kau_pkg::KIND_ASSIGN;
                  r.nearest = best[2:0];
                  r.min_distance = acc[best];
                  foreach (acc[k]) acc[k] = '0;
                  expected_rsp.push_back(r);
               end
            end
         endcase
      endfunction

      // returns 1 when the response matches the oldest prediction
      function bit match_result(kau_pkg::rsp_type got, output string why);
         kau_pkg::rsp_type e;
         if (expected_rsp.size() == 0) begin
            why = $sformatf("unexpected response %p", got);
            return 0;
         end
         e = expected_rsp.pop_front();
         if (got.kind !== e.kind || got.nearest !== e.nearest ||
             got.min_distance !== e.min_distance || got.read_value !== e.read_value) begin
            why = $sformatf("got kind %0d near %0d dist %0d rd %h, want %0d %0d %0d %h",
                            got.kind, got.nearest, got.min_distance, got.read_value,
                            e.kind, e.nearest, e.min_distance, e.read_value);
            return 0;
         end
         why = "";
         return 1;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_data;
   int          mismatches = 0;
   bit          long_hold = 0;
   cluster_tracker tracker = new();

   kau_if #(.T(kau_pkg::req_type)) req_ch ();
   kau_if #(.T(kau_pkg::rsp_type)) rsp_ch ();

   kmeans_assign_and_update_core u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400_000_000;
      $display("kmeans_assign_and_update_core regression: fail");
      $finish;
   end

   task automatic report(string why);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, why);
   endtask

   // response side: random stall per word, one long hold on request
   initial begin
      int gap;
      string why;
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (long_hold) begin
            gap = 600;
            long_hold = 0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (!tracker.match_result(rsp_ch.data, why)) report(why);
      end
   end

   task automatic send_word(kau_pkg::req_type w, bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      do @(posedge clock); while (!req_ch.ready);
      tracker.absorb_word(w);
   endtask

   task automatic send_cmd(kau_pkg::cmd_type c, int cl, int dm, int v, bit lst);
      kau_pkg::req_type w;
      w.command = c;
      w.cluster = cl[2:0];
      w.dim = dm[3:0];
      w.value = v[15:0];
      w.last = lst;
      send_word(w, 1'b0);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_pnorm(logic [2:0] v);
      drain();
      csr_write <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      tracker.pnorm = v;
   endtask

   task automatic random_phase(int n, bit burst);
      kau_pkg::req_type w;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         w.cluster = 3'($urandom_range(0, 7));
         w.dim = 4'($urandom_range(0, 15));
         w.value = 16'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) :
                       ($urandom_range(0, 1) == 0) ? 16'hFFFF - $urandom_range(0, 255) :
                       $urandom_range(0, 65535));
         w.last = 1'b0;
         if (r < 10) w.command = kau_pkg::CMD_LOAD;
         else if (r < 17) w.command = kau_pkg::CMD_READ;
         else if (r < 19) w.command = kau_pkg::CMD_UPDATE;
         else begin
            w.command = kau_pkg::CMD_POINT;
            w.last = ($urandom_range(0, 5) == 0);
         end
         if (w.command != kau_pkg::CMD_POINT && $urandom_range(0, 1)) w.last = 1'b1;
         send_word(w, burst && ($urandom_range(0, 3) != 0));
      end
   endtask

   initial begin
      logic [2:0] pn_seq[7] = '{3'd1, 3'd4, 3'd3, 3'd0, 3'd7, 3'd5, 3'd2};
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, reads, a full point that fills the buffer, ties
      send_cmd(kau_pkg::CMD_LOAD, 7, 15, 16'hFFFF, 1'b1);
      send_cmd(kau_pkg::CMD_LOAD, 0, 0, 0, 1'b0);
      send_cmd(kau_pkg::CMD_READ, 7, 15, 0, 1'b0);
      send_cmd(kau_pkg::CMD_READ, 0, 0, 16'hFFFF, 1'b1);
      for (int d = 0; d < NDIM; d++)
         send_cmd(kau_pkg::CMD_POINT, 0, d, (d % 2) ? 16'hFFFF : 0, d == NDIM - 1);
      send_cmd(kau_pkg::CMD_POINT, 7, 15, 16'h8000, 1'b1);
      send_cmd(kau_pkg::CMD_UPDATE, 0, 0, 0, 1'b0);
      send_cmd(kau_pkg::CMD_READ, 0, 15, 0, 1'b0);

      for (int ph = 0; ph < 7; ph++) begin
         set_pnorm(pn_seq[ph]);
         if (ph == 2) long_hold = 1;
         random_phase(62, ph == 2 || ph == 5);
      end

      drain();
      if (mismatches == 0)
         $display("kmeans_assign_and_update_core regression: pass");
      else
         $display("kmeans_assign_and_update_core regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
